// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge outside reset
`define GFBA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define GFBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/gfba_pkg.sv
// ----------------------------------------------------------------------------
// gfba_pkg
// Types, sizes and codes of the grouped free block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package gfba_pkg;

	localparam int GROUP_CAPACITY = 128;
	localparam int GROUP_LEVELS   = 64;
	localparam int BLOCK_BITS     = 24;

	localparam int GSIZE_BITS    = 8;
	localparam int GSIZE_RESET   = 100;
	localparam int ENTRIES_BITS  = 8;
	localparam int SPILLED_BITS  = 6;
	localparam int STATUS_BITS   = 2;

	localparam int TOP_BITS      = $clog2(GROUP_CAPACITY + 1);
	localparam int LEVEL_BITS    = (GROUP_LEVELS > 1) ? $clog2(GROUP_LEVELS) : 1;
	localparam int STORE_DEPTH   = GROUP_LEVELS * GROUP_CAPACITY;
	localparam int ADDR_BITS     = $clog2(STORE_DEPTH);
	localparam int CMP_BITS      = ((TOP_BITS > GSIZE_BITS) ? TOP_BITS : GSIZE_BITS) + 1;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} gfba_op_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK         = 2'd0,
		ST_NO_SPACE   = 2'd1,
		ST_STORE_FULL = 2'd2,
		ST_ZERO_BLOCK = 2'd3
	} gfba_status_t;

	typedef enum logic {
		GFBA_IDLE = 1'b0,
		GFBA_EXEC = 1'b1
	} gfba_state_t;

	typedef struct packed {
		logic start;
		logic commit;
	} gfba_cmd_t;

	typedef struct packed {
		logic out_busy;
	} gfba_sts_t;

endpackage

`default_nettype wire

// File: rtl/core/gfba_if.sv
// ----------------------------------------------------------------------------
// gfba channel interfaces
// Request, response and configuration channels with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface gfba_req_if;
	logic                             valid;
	logic                             ready;
	logic                             opcode;
	logic [gfba_pkg::BLOCK_BITS-1:0]  block_number;

	modport source (output valid, output opcode, output block_number, input ready);
	modport sink   (input valid, input opcode, input block_number, output ready);
endinterface

interface gfba_rsp_if;
	logic                               valid;
	logic                               ready;
	logic [gfba_pkg::STATUS_BITS-1:0]   status;
	logic [gfba_pkg::BLOCK_BITS-1:0]    allocated_block;
	logic [gfba_pkg::ENTRIES_BITS-1:0]  entries_in_top_group;
	logic [gfba_pkg::SPILLED_BITS-1:0]  spilled_groups;
	logic                               modified;

	modport source (output valid, output status, output allocated_block,
		output entries_in_top_group, output spilled_groups, output modified,
		input ready);
	modport sink   (input valid, input status, input allocated_block,
		input entries_in_top_group, input spilled_groups, input modified,
		output ready);
endinterface

interface gfba_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [gfba_pkg::GSIZE_BITS-1:0]  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/gfba_datapath.sv
// ----------------------------------------------------------------------------
// gfba_datapath
// Entry store, spill count store, group pointers and the response register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module gfba_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  gfba_pkg::gfba_cmd_t                cmd,
	output gfba_pkg::gfba_sts_t                sts,
	input  logic                               opcode,
	input  logic [gfba_pkg::BLOCK_BITS-1:0]    block_number,
	input  logic                               cfg_we,
	input  logic [gfba_pkg::GSIZE_BITS-1:0]    cfg_data,
	input  logic                               rsp_ready,
	output logic                               rsp_valid,
	output logic [gfba_pkg::STATUS_BITS-1:0]   status,
	output logic [gfba_pkg::BLOCK_BITS-1:0]    allocated_block,
	output logic [gfba_pkg::ENTRIES_BITS-1:0]  entries_in_top_group,
	output logic [gfba_pkg::SPILLED_BITS-1:0]  spilled_groups,
	output logic                               modified
);

	logic [gfba_pkg::BLOCK_BITS-1:0]  store_mem [gfba_pkg::STORE_DEPTH];
	logic [gfba_pkg::TOP_BITS-1:0]    spill_mem [gfba_pkg::GROUP_LEVELS];

	// item registers
	gfba_pkg::gfba_op_t               op_q;
	logic [gfba_pkg::BLOCK_BITS-1:0]  blk_q;
	logic [gfba_pkg::BLOCK_BITS-1:0]  rd_data_q;
	logic [gfba_pkg::TOP_BITS-1:0]    spill_rd_q;
	logic                             void_q;

	// allocator state
	logic [gfba_pkg::TOP_BITS-1:0]    top_q;
	logic [gfba_pkg::LEVEL_BITS-1:0]  level_q;
	logic                             modified_q;
	logic [gfba_pkg::GSIZE_BITS-1:0]  gsize_q;

	// response register
	logic                               out_valid_q;
	gfba_pkg::gfba_status_t             out_status_q;
	logic [gfba_pkg::BLOCK_BITS-1:0]    out_block_q;
	logic [gfba_pkg::ENTRIES_BITS-1:0]  out_top_q;
	logic [gfba_pkg::SPILLED_BITS-1:0]  out_level_q;
	logic                               out_mod_q;

	logic [gfba_pkg::TOP_BITS-1:0]    top_m1;
	logic [gfba_pkg::LEVEL_BITS-1:0]  level_m1;
	logic [gfba_pkg::LEVEL_BITS-1:0]  level_p1;
	logic [gfba_pkg::ADDR_BITS-1:0]   base_addr;
	logic [gfba_pkg::ADDR_BITS-1:0]   next_base_addr;
	logic [gfba_pkg::ADDR_BITS-1:0]   store_raddr;
	logic [gfba_pkg::ADDR_BITS-1:0]   store_waddr;
	logic [gfba_pkg::CMP_BITS-1:0]    eff_size;
	logic                             spill_need;
	logic                             level_full;
	logic [gfba_pkg::BLOCK_BITS-1:0]  pop_val;
	logic                             store_we;
	logic                             spill_we;
	logic                             push_ok;

	gfba_pkg::gfba_status_t           status_n;
	logic [gfba_pkg::BLOCK_BITS-1:0]  handed_n;
	logic [gfba_pkg::TOP_BITS-1:0]    top_n;
	logic [gfba_pkg::LEVEL_BITS-1:0]  level_n;
	logic                             mod_n;

	assign top_m1         = top_q - 1'b1;
	assign level_m1       = level_q - 1'b1;
	assign level_p1       = level_q + 1'b1;
	assign base_addr      = gfba_pkg::ADDR_BITS'(level_q)
		* gfba_pkg::ADDR_BITS'(gfba_pkg::GROUP_CAPACITY);
	assign next_base_addr = gfba_pkg::ADDR_BITS'(level_p1)
		* gfba_pkg::ADDR_BITS'(gfba_pkg::GROUP_CAPACITY);
	assign store_raddr    = base_addr + gfba_pkg::ADDR_BITS'(top_m1);
	assign level_full     = (level_q == gfba_pkg::LEVEL_BITS'(gfba_pkg::GROUP_LEVELS - 1));
	assign spill_need     = (gfba_pkg::CMP_BITS'(top_q) >= eff_size);
	assign pop_val        = void_q ? '0 : rd_data_q;

	always_comb begin
		if (gsize_q < gfba_pkg::GSIZE_BITS'(2)) begin
			eff_size = gfba_pkg::CMP_BITS'(2);
		end else if (gfba_pkg::CMP_BITS'(gsize_q)
				> gfba_pkg::CMP_BITS'(gfba_pkg::GROUP_CAPACITY)) begin
			eff_size = gfba_pkg::CMP_BITS'(gfba_pkg::GROUP_CAPACITY);
		end else begin
			eff_size = gfba_pkg::CMP_BITS'(gsize_q);
		end
	end

	always_comb begin
		status_n    = gfba_pkg::ST_OK;
		handed_n    = '0;
		top_n       = top_q;
		level_n     = level_q;
		mod_n       = modified_q;
		push_ok     = 1'b0;
		spill_we    = 1'b0;
		store_waddr = base_addr + gfba_pkg::ADDR_BITS'(top_q);
		if (op_q == gfba_pkg::OP_ALLOC) begin
			if (pop_val == '0) begin
				status_n = gfba_pkg::ST_NO_SPACE;
			end else begin
				handed_n = pop_val;
				mod_n    = 1'b1;
				top_n    = top_m1;
				if (top_m1 == '0 && level_q != '0) begin
					level_n = level_m1;
					top_n   = spill_rd_q;
				end
			end
		end else if (blk_q == '0) begin
			status_n = gfba_pkg::ST_ZERO_BLOCK;
		end else if (spill_need && level_full) begin
			status_n = gfba_pkg::ST_STORE_FULL;
		end else begin
			push_ok = 1'b1;
			mod_n   = 1'b1;
			if (spill_need) begin
				spill_we    = 1'b1;
				level_n     = level_p1;
				store_waddr = next_base_addr;
				top_n       = gfba_pkg::TOP_BITS'(1);
			end else begin
				top_n = top_q + 1'b1;
			end
		end
	end

	assign store_we = cmd.commit && push_ok;

	// level zero, entry zero is the sentinel and is never written
	always_ff @(posedge clk) begin
		if (store_we) begin
			store_mem[store_waddr] <= blk_q;
		end
		if (cmd.start) begin
			rd_data_q <= store_mem[store_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && spill_we) begin
			spill_mem[level_q] <= top_q;
		end
		if (cmd.start) begin
			spill_rd_q <= spill_mem[level_m1];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q   <= gfba_pkg::gfba_op_t'(opcode);
			blk_q  <= block_number;
			void_q <= (top_q == '0) || (store_raddr == '0);
		end
		if (cmd.commit) begin
			out_status_q <= status_n;
			out_block_q  <= handed_n;
			out_top_q    <= gfba_pkg::ENTRIES_BITS'(top_n);
			out_level_q  <= gfba_pkg::SPILLED_BITS'(level_n);
			out_mod_q    <= mod_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q       <= gfba_pkg::TOP_BITS'(1);
			level_q     <= '0;
			modified_q  <= 1'b0;
			gsize_q     <= gfba_pkg::GSIZE_BITS'(gfba_pkg::GSIZE_RESET);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				gsize_q <= cfg_data;
			end
			if (cmd.commit) begin
				top_q      <= top_n;
				level_q    <= level_n;
				modified_q <= mod_n;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.out_busy         = out_valid_q && !rsp_ready;
	assign rsp_valid            = out_valid_q;
	assign status               = out_status_q;
	assign allocated_block      = out_block_q;
	assign entries_in_top_group = out_top_q;
	assign spilled_groups       = out_level_q;
	assign modified             = out_mod_q;

	`GFBA_ASSERT(a_top_range, clk, arst_n,
		top_q != '0 && top_q <= gfba_pkg::TOP_BITS'(gfba_pkg::GROUP_CAPACITY),
		"top group count out of range")
	`GFBA_ASSERT_NEXT(a_hold_idle, clk, arst_n, !cmd.commit,
		$stable(top_q) && $stable(level_q) && $stable(modified_q),
		"pointers moved without a commit")
	`GFBA_ASSERT_NEXT(a_push_marks, clk, arst_n, cmd.commit && push_ok,
		modified_q && out_valid_q && out_status_q == gfba_pkg::ST_OK,
		"successful free not reflected")

endmodule

`default_nettype wire

// File: rtl/core/gfba_ctrl.sv
// ----------------------------------------------------------------------------
// gfba_ctrl
// Two-state sequencer: take a request, then commit it once the response
// register can take the result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module gfba_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  gfba_pkg::gfba_sts_t  sts,
	output gfba_pkg::gfba_cmd_t  cmd
);

	gfba_pkg::gfba_state_t state_q;
	gfba_pkg::gfba_state_t state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gfba_pkg::GFBA_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n    = state_q;
		req_ready  = 1'b0;
		cmd.start  = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			gfba_pkg::GFBA_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.start = 1'b1;
					state_n   = gfba_pkg::GFBA_EXEC;
				end
			end
			gfba_pkg::GFBA_EXEC: begin
				if (!sts.out_busy) begin
					cmd.commit = 1'b1;
					state_n    = gfba_pkg::GFBA_IDLE;
				end
			end
			default: begin
				state_n = gfba_pkg::GFBA_IDLE;
			end
		endcase
	end

	`GFBA_ASSERT_NEXT(a_commit_after_start, clk, arst_n, cmd.commit,
		$past(cmd.start) || $past(state_q == gfba_pkg::GFBA_EXEC),
		"commit without a pending request")
	`GFBA_ASSERT(a_one_cmd, clk, arst_n, !(cmd.start && cmd.commit),
		"start and commit in the same cycle")

endmodule

`default_nettype wire

// File: rtl/core/grouped_free_block_allocator.sv
// The request beat registers the request and the entry store read; the
// EXEC state then commits the result to the response register, which drives
// rsp.valid. A new request is taken only once the last one has committed, as
// req.ready is high only in IDLE; the pointers update at that commit.
// A stalled response holds the block in its EXEC state until taken.
// Reset (arst_n, asynchronous): one sentinel entry, no spilled groups, group
// size 100; no clearing pass, the block takes requests straight after reset.
// ----------------------------------------------------------------------------
// grouped_free_block_allocator
// Grouped free block list allocator with spilled groups in an internal store.
// ----------------------------------------------------------------------------
`default_nettype none

module grouped_free_block_allocator (
	input  logic         clk,
	input  logic         arst_n,
	gfba_req_if.sink     req,
	gfba_rsp_if.source   rsp,
	gfba_cfg_if.sink     cfg
);

	gfba_pkg::gfba_cmd_t cmd;
	gfba_pkg::gfba_sts_t sts;

	assign cfg.ready = 1'b1;

	gfba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	gfba_datapath u_datapath (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cmd                  (cmd),
		.sts                  (sts),
		.opcode               (req.opcode),
		.block_number         (req.block_number),
		.cfg_we               (cfg.valid),
		.cfg_data             (cfg.data),
		.rsp_ready            (rsp.ready),
		.rsp_valid            (rsp.valid),
		.status               (rsp.status),
		.allocated_block      (rsp.allocated_block),
		.entries_in_top_group (rsp.entries_in_top_group),
		.spilled_groups       (rsp.spilled_groups),
		.modified             (rsp.modified)
	);

endmodule

`default_nettype wire
